/* src/tifl_pkg.sv */
`default_nettype none
package tifl_pkg;

  localparam int DATA_BYTES = 65536;
  localparam int MAX_DIRS   = 8;

  localparam int ADDR_W = $clog2(DATA_BYTES);
  localparam int LEN_W  = $clog2(DATA_BYTES + 1);
  localparam int DC_W   = $clog2(MAX_DIRS + 1);
  localparam int K_W    = $clog2(MAX_DIRS);
  // Wide enough for a 32-bit pointer plus a 35-bit byte size.
  localparam int AX_W   = 38;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_LE    = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_BAD_DIR   = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd5;

  localparam logic [3:0] T_RATIONAL  = 4'd5;
  localparam logic [3:0] T_SRATIONAL = 4'd10;

  localparam logic [15:0] EXIF_SUB_TAG = 16'h8769;
  localparam logic [3:0]  MAX_TYPE     = 4'd12;
  localparam logic [7:0]  ORDER_MARK   = 8'h49;
  localparam logic [AX_W-1:0] ENTRY_BYTES = AX_W'(12);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  byte_value;
    logic        last_byte;
    logic [15:0] tag_id;
    logic [2:0]  ifd_index;
    logic        search_all;
    logic [15:0] read_address;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  ifd_count;
    logic [2:0]  found_ifd;
    logic [3:0]  field_type;
    logic [34:0] byte_size;
    logic [31:0] int_value;
    logic [31:0] numerator;
    logic [31:0] denominator;
    logic [15:0] data_offset;
    logic [7:0]  read_byte;
  } rsp_item_t;

  // Element size of a TIFF type, as a left shift of the count.
  function automatic logic [1:0] elem_shift(input logic [3:0] t);
    case (t)
      4'd3, 4'd8:         elem_shift = 2'd1;
      4'd4, 4'd9, 4'd11:  elem_shift = 2'd2;
      4'd5, 4'd10, 4'd12: elem_shift = 2'd3;
      default:            elem_shift = 2'd0;
    endcase
  endfunction

  function automatic logic int_type(input logic [3:0] t);
    int_type = (t == 4'd1) || (t == 4'd3) || (t == 4'd4) ||
               (t == 4'd6) || (t == 4'd8) || (t == 4'd9);
  endfunction

  // True when bytes a .. a+n-1 all lie below the loaded length.
  function automatic logic have(input logic [AX_W-1:0] a, input logic [AX_W-1:0] n,
                                input logic [LEN_W-1:0] len);
    have = (a + n) <= AX_W'(len);
  endfunction

endpackage
`default_nettype wire

/* src/tifl_req_if.sv */
`default_nettype none
interface tifl_req_if;
  logic                valid;
  logic                ready;
  tifl_pkg::req_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/tifl_rsp_if.sv */
`default_nettype none
interface tifl_rsp_if;
  logic                valid;
  logic                ready;
  tifl_pkg::rsp_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/tiff_ifd_tag_lookup_unit.sv */
`default_nettype none
// Little-endian TIFF/EXIF directory parser and tag lookup.
// Items enter on req and results leave on rsp, both valid/ready channels.
// A load item (cmd 0) stores one byte in the 64 KiB block memory and
// gives no result unless last_byte is set. The last byte
// starts the directory parse, whose result carries the status and the
// directory count. A query (cmd 1) walks the 12-byte entries of one
// directory, or of all directories in order, and returns the decoded entry.
// A read (cmd 2) returns one stored byte.
// Parse and query traffic goes through one sequencer that fetches one byte
// at a time over the single memory read port, so a parse or query takes
// longer the more bytes it fetches: two bytes per skipped entry, plus
// the header, directory count and matched entry.
// Run time thus grows with the number of entries walked.
// The block is ready only while its sequencer is idle. A finished result
// sits in the output register; a new item is accepted while it waits, and
// the next result waits until the receiver has taken the previous one.
// Reset clears the load length, the directory count and the parsed flag;
// the memory contents are not cleared and need no clearing pass.
module tiff_ifd_tag_lookup_unit (
  input  wire logic clk,
  input  wire logic rst,
  tifl_req_if.sink  req,
  tifl_rsp_if.source rsp
);
  import tifl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_READ_OUT, S_FETCH, S_FCAP, S_EMIT,
    P_MAGIC, P_HDR, P_DIR, P_CNT, P_PCHK, P_NEXT,
    L_START, L_N, L_ENT, L_TAG, L_TYPE, L_CNT, L_SIZE, L_PTR, L_PCHK,
    L_INT, L_INTV, L_RAT, L_NUM, L_DEN, L_END
  } state_t;

  typedef enum logic [1:0] {EK_PARSE, EK_QUERY, EK_READ} emit_kind_t;

  state_t state, ret_state;
  emit_kind_t em_kind;

  logic [7:0]  mem [DATA_BYTES];
  logic [7:0]  mem_q;
  logic [ADDR_W-1:0] mem_ra;
  logic        mem_we;
  logic [LEN_W-1:0] len_eff;

  logic [LEN_W-1:0] len;
  logic        closed, parsed;
  logic [DC_W-1:0] dir_count;
  logic [15:0] ifd_base [MAX_DIRS];

  logic [ADDR_W-1:0] f_addr;
  logic [2:0]  f_len;
  logic [1:0]  f_idx;
  logic [31:0] acc;

  logic [AX_W-1:0] off, p_addr, e_addr, l_dat;
  logic [15:0] tag, n_ent, i_ent;
  logic [K_W-1:0] k;
  logic        all_q, mode_parse;
  logic [3:0]  l_type;
  logic [31:0] l_cnt, intv, num, den;
  logic [34:0] l_size;
  logic [2:0]  l_status, em_status;
  logic [7:0]  rbyte;
  logic        out_free, accept;
  rsp_item_t   em_data;

  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign accept = req.valid && req.ready;
  assign len_eff = closed ? '0 : len;
  assign mem_we = accept && (req.data.cmd == CMD_LOAD) && (len_eff < LEN_W'(DATA_BYTES));
  assign mem_ra = (state == S_FETCH) ? f_addr : req.data.read_address[ADDR_W-1:0];

  always_comb begin
    em_data           = '0;
    em_data.status    = em_status;
    em_data.ifd_count = 4'(dir_count);
    if (em_status == ST_OK && em_kind == EK_QUERY) begin
      em_data.found_ifd   = 3'(k);
      em_data.field_type  = l_type;
      em_data.byte_size   = l_size;
      em_data.int_value   = intv;
      em_data.numerator   = num;
      em_data.denominator = den;
      em_data.data_offset = l_dat[15:0];
    end
    if (em_status == ST_OK && em_kind == EK_READ) begin
      em_data.read_byte = rbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[len_eff[ADDR_W-1:0]] <= req.data.byte_value;
    end
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      closed    <= 1'b0;
      parsed    <= 1'b0;
      dir_count <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // A result leaving in the emit state is replaced there.
      if (rsp.valid && rsp.ready && state != S_EMIT) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.data.cmd)
              CMD_LOAD: begin
                len <= mem_we ? len_eff + 1'b1 : len_eff;
                if (req.data.last_byte) begin
                  closed     <= 1'b1;
                  dir_count  <= '0;
                  parsed     <= 1'b0;
                  mode_parse <= 1'b1;
                  em_kind    <= EK_PARSE;
                  f_addr     <= '0;
                  f_len      <= 3'd1;
                  f_idx      <= '0;
                  acc        <= '0;
                  ret_state  <= P_MAGIC;
                  state      <= S_FETCH;
                end else if (closed) begin
                  dir_count <= '0;
                  parsed    <= 1'b0;
                  closed    <= 1'b0;
                end
              end
              CMD_QUERY: begin
                mode_parse <= 1'b0;
                em_kind    <= EK_QUERY;
                tag        <= req.data.tag_id;
                all_q      <= req.data.search_all;
                if (!parsed) begin
                  em_status <= ST_BAD_DIR;
                  state     <= S_EMIT;
                end else if (req.data.search_all) begin
                  k <= '0;
                  if (dir_count == '0) begin
                    em_status <= ST_NOT_FOUND;
                    state     <= S_EMIT;
                  end else begin
                    state <= L_START;
                  end
                end else if (32'(req.data.ifd_index) >= 32'(dir_count)) begin
                  em_status <= ST_BAD_DIR;
                  state     <= S_EMIT;
                end else begin
                  k     <= K_W'(req.data.ifd_index);
                  state <= L_START;
                end
              end
              CMD_READ: begin
                em_kind <= EK_READ;
                if (LEN_W'(req.data.read_address) < len) begin
                  em_status <= ST_OK;
                  state     <= S_READ_OUT;
                end else begin
                  em_status <= ST_RANGE;
                  rbyte     <= '0;
                  state     <= S_EMIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ_OUT: begin
          rbyte <= mem_q;
          state <= S_EMIT;
        end
        S_FETCH: begin
          state <= S_FCAP;
        end
        S_FCAP: begin
          acc[8*f_idx +: 8] <= mem_q;
          f_addr <= f_addr + 1'b1;
          f_idx  <= f_idx + 1'b1;
          state  <= (3'(f_idx) + 3'd1 == f_len) ? ret_state : S_FETCH;
        end
        S_EMIT: begin
          if (out_free) begin
            rsp.valid <= 1'b1;
            rsp.data  <= em_data;
            state     <= S_IDLE;
          end
        end
        P_MAGIC: begin
          if (acc[7:0] != ORDER_MARK) begin
            em_status <= ST_NOT_LE;
            state     <= S_EMIT;
          end else if (len < LEN_W'(8)) begin
            em_status <= ST_RANGE;
            state     <= S_EMIT;
          end else begin
            f_addr    <= ADDR_W'(4);
            f_len     <= 3'd4;
            f_idx     <= '0;
            acc       <= '0;
            ret_state <= P_HDR;
            state     <= S_FETCH;
          end
        end
        P_HDR: begin
          off   <= AX_W'(acc);
          state <= P_DIR;
        end
        P_DIR: begin
          if (dir_count >= DC_W'(MAX_DIRS)) begin
            em_status <= ST_BAD_DIR;
            state     <= S_EMIT;
          end else if (!have(off, AX_W'(2), len)) begin
            em_status <= ST_RANGE;
            state     <= S_EMIT;
          end else begin
            ifd_base[dir_count[K_W-1:0]] <= off[15:0];
            dir_count <= dir_count + 1'b1;
            f_addr    <= off[ADDR_W-1:0];
            f_len     <= 3'd2;
            f_idx     <= '0;
            acc       <= '0;
            ret_state <= P_CNT;
            state     <= S_FETCH;
          end
        end
        P_CNT: begin
          // Twelve bytes per entry as two shifted copies of the count.
          p_addr <= off + AX_W'(2) + (AX_W'(acc[15:0]) << 3) + (AX_W'(acc[15:0]) << 2);
          state  <= P_PCHK;
        end
        P_PCHK: begin
          if (!have(p_addr, AX_W'(4), len)) begin
            em_status <= ST_RANGE;
            state     <= S_EMIT;
          end else begin
            f_addr    <= p_addr[ADDR_W-1:0];
            f_len     <= 3'd4;
            f_idx     <= '0;
            acc       <= '0;
            ret_state <= P_NEXT;
            state     <= S_FETCH;
          end
        end
        P_NEXT: begin
          off <= AX_W'(acc);
          if (acc == '0) begin
            k     <= '0;
            tag   <= EXIF_SUB_TAG;
            state <= L_START;
          end else begin
            state <= P_DIR;
          end
        end
        L_START: begin
          if (32'(k) >= 32'(dir_count)) begin
            l_status <= ST_BAD_DIR;
            state    <= L_END;
          end else if (!have(AX_W'(ifd_base[k]), AX_W'(2), len)) begin
            l_status <= ST_RANGE;
            state    <= L_END;
          end else begin
            e_addr    <= AX_W'(ifd_base[k]) + AX_W'(2);
            f_addr    <= ifd_base[k][ADDR_W-1:0];
            f_len     <= 3'd2;
            f_idx     <= '0;
            acc       <= '0;
            ret_state <= L_N;
            state     <= S_FETCH;
          end
        end
        L_N: begin
          n_ent <= acc[15:0];
          i_ent <= '0;
          state <= L_ENT;
        end
        L_ENT: begin
          if (i_ent == n_ent) begin
            l_status <= ST_NOT_FOUND;
            state    <= L_END;
          end else if (!have(e_addr, ENTRY_BYTES, len)) begin
            l_status <= ST_RANGE;
            state    <= L_END;
          end else begin
            f_addr    <= e_addr[ADDR_W-1:0];
            f_len     <= 3'd2;
            f_idx     <= '0;
            acc       <= '0;
            ret_state <= L_TAG;
            state     <= S_FETCH;
          end
        end
        L_TAG: begin
          if (acc[15:0] == tag) begin
            f_addr    <= f_addr;
            f_len     <= 3'd2;
            f_idx     <= '0;
            acc       <= '0;
            ret_state <= L_TYPE;
            state     <= S_FETCH;
          end else begin
            e_addr <= e_addr + ENTRY_BYTES;
            i_ent  <= i_ent + 1'b1;
            state  <= L_ENT;
          end
        end
        L_TYPE: begin
          if (acc[15:0] == '0 || acc[15:0] > 16'(MAX_TYPE)) begin
            l_status <= ST_BAD_TYPE;
            state    <= L_END;
          end else begin
            l_type    <= acc[3:0];
            f_len     <= 3'd4;
            f_idx     <= '0;
            acc       <= '0;
            ret_state <= L_CNT;
            state     <= S_FETCH;
          end
        end
        L_CNT: begin
          l_cnt  <= acc;
          l_size <= 35'(acc) << elem_shift(l_type);
          l_dat  <= e_addr + AX_W'(8);
          intv   <= '0;
          num    <= '0;
          den    <= '0;
          state  <= L_SIZE;
        end
        L_SIZE: begin
          if (l_size > 35'd4) begin
            f_addr    <= f_addr;
            f_len     <= 3'd4;
            f_idx     <= '0;
            acc       <= '0;
            ret_state <= L_PTR;
            state     <= S_FETCH;
          end else begin
            state <= L_INT;
          end
        end
        L_PTR: begin
          l_dat <= AX_W'(acc);
          state <= L_PCHK;
        end
        L_PCHK: begin
          if (!have(l_dat, AX_W'(l_size), len)) begin
            l_status <= ST_RANGE;
            state    <= L_END;
          end else begin
            state <= L_INT;
          end
        end
        L_INT: begin
          if (l_cnt != '0 && int_type(l_type)) begin
            f_addr    <= l_dat[ADDR_W-1:0];
            f_len     <= 3'd1 << elem_shift(l_type);
            f_idx     <= '0;
            acc       <= '0;
            ret_state <= L_INTV;
            state     <= S_FETCH;
          end else begin
            state <= L_RAT;
          end
        end
        L_INTV: begin
          intv  <= acc;
          state <= L_RAT;
        end
        L_RAT: begin
          if (l_cnt != '0 && (l_type == T_RATIONAL || l_type == T_SRATIONAL)) begin
            // The last rational sits in the final eight bytes of the data.
            f_addr    <= ADDR_W'(l_dat + AX_W'(l_size) - AX_W'(8));
            f_len     <= 3'd4;
            f_idx     <= '0;
            acc       <= '0;
            ret_state <= L_NUM;
            state     <= S_FETCH;
          end else begin
            l_status <= ST_OK;
            state    <= L_END;
          end
        end
        L_NUM: begin
          num       <= acc;
          f_len     <= 3'd4;
          f_idx     <= '0;
          acc       <= '0;
          ret_state <= L_DEN;
          state     <= S_FETCH;
        end
        L_DEN: begin
          den      <= acc;
          l_status <= ST_OK;
          state    <= L_END;
        end
        L_END: begin
          if (mode_parse) begin
            state <= S_EMIT;
            if (l_status == ST_OK) begin
              if (!int_type(l_type)) begin
                em_status <= ST_BAD_TYPE;
              end else if (dir_count >= DC_W'(MAX_DIRS)) begin
                em_status <= ST_BAD_DIR;
              end else if (!have(AX_W'(intv), AX_W'(2), len)) begin
                em_status <= ST_RANGE;
              end else begin
                ifd_base[dir_count[K_W-1:0]] <= intv[15:0];
                dir_count <= dir_count + 1'b1;
                parsed    <= 1'b1;
                em_status <= ST_OK;
              end
            end else if (l_status == ST_NOT_FOUND) begin
              parsed    <= 1'b1;
              em_status <= ST_OK;
            end else begin
              em_status <= l_status;
            end
          end else if (l_status == ST_NOT_FOUND && all_q &&
                       32'(k) + 32'd1 < 32'(dir_count)) begin
            k     <= k + 1'b1;
            state <= L_START;
          end else begin
            em_status <= l_status;
            state     <= S_EMIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_dir_bound: assert property (@(posedge clk) disable iff (rst)
    dir_count <= DC_W'(MAX_DIRS))
    else $error("directory count beyond capacity");

  a_parsed_dirs: assert property (@(posedge clk) disable iff (rst)
    parsed |-> dir_count != '0)
    else $error("parsed block without directories");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(DATA_BYTES))
    else $error("load length beyond memory size");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.status != ST_OK |->
      rsp.data.byte_size == '0 && rsp.data.read_byte == '0 && rsp.data.int_value == '0)
    else $error("error item carries payload");

  a_plain_load: assert property (@(posedge clk) disable iff (rst)
    accept && req.data.cmd == CMD_LOAD && !req.data.last_byte |=> state == S_IDLE)
    else $error("plain load item started the sequencer");

endmodule
`default_nettype wire
